// ----- src/tnc_pkg.sv -----
// Shared constants for the triangle normal and centroid block.
`default_nettype none
package tnc_pkg;

  // Default vertex coordinate width (signed, 16 fraction bits).
  localparam int COORD_WIDTH = 32;
  // Default fraction bits of the unit normal components.
  localparam int NORM_FRAC_BITS = 14;
  // Fraction bits of the unit edge vectors.
  localparam int EDGE_FRAC = 30;
  // Width of a magnitude after alignment; the top bit of the largest magnitude is set unless the vector is zero.
  localparam int ALIGN_BITS = 31;
  // Divisor of the vertex sum for the centroid.
  localparam int CENTROID_DIV = 3;

endpackage
`default_nettype wire

// ----- src/tnc_unit.sv -----
// Pipelined unit-vector scaler: align, square, integer square root, rounded divide.
`default_nettype none
module tnc_unit #(
  parameter int IW  = 33,
  parameter int K   = 30,
  parameter int SBW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [IW-1:0] vx_i,
  input  logic signed [IW-1:0] vy_i,
  input  logic signed [IW-1:0] vz_i,
  input  logic [SBW-1:0]       side_i,
  output logic                 vld_o,
  output logic signed [K+1:0]  ux_o,
  output logic signed [K+1:0]  uy_o,
  output logic signed [K+1:0]  uz_o,
  output logic                 nz_o,
  output logic [SBW-1:0]       side_o
);
  import tnc_pkg::*;

  localparam int AB   = ALIGN_BITS;
  localparam int SW   = $clog2(IW + 1);
  localparam int SQW  = 2 * AB;
  localparam int SUMW = SQW + 2;
  localparam int RW   = SUMW / 2;
  localparam int REMW = RW + 2;
  localparam int NW   = AB + K + 1;
  localparam int QW   = K + 1;

  typedef struct packed {
    logic [2:0][AB-1:0] m;
    logic [2:0]         neg;
    logic               nz;
    logic [SBW-1:0]     side;
  } ctx_t;

  // Magnitude and sign of each component.
  logic               a_vld_r;
  logic [2:0][IW-1:0] a_mag_r, a_mag_nxt;
  logic [2:0]         a_neg_r;
  logic [SBW-1:0]     a_side_r;
  logic [2:0][IW-1:0] vin;

  assign vin = {vz_i, vy_i, vx_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag_nxt[i] = vin[i][IW-1] ? (~vin[i] + 1'b1) : vin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= a_mag_nxt;
      a_neg_r  <= {vz_i[IW-1], vy_i[IW-1], vx_i[IW-1]};
      a_side_r <= side_i;
    end
  end

  // Position of the leading one over all three magnitudes.
  logic               b_vld_r;
  logic [2:0][IW-1:0] b_mag_r;
  logic [2:0]         b_neg_r;
  logic               b_nz_r;
  logic [SW-1:0]      b_sh_r, b_sh_nxt;
  logic [SBW-1:0]     b_side_r;
  logic [IW-1:0]      orv;

  always_comb begin
    orv = a_mag_r[0] | a_mag_r[1] | a_mag_r[2];
    b_sh_nxt = '0;
    for (int i = 0; i < IW; i++) begin
      if (orv[i]) begin
        b_sh_nxt = SW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_nz_r   <= |orv;
      b_sh_r   <= b_sh_nxt;
      b_side_r <= a_side_r;
    end
  end

  // Common shift puts the largest magnitude's top bit at AB-1.
  logic c_vld_r;
  ctx_t c_ctx_r, c_ctx_nxt;
  logic [IW+AB-1:0] ext [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {b_mag_r[i], {AB{1'b0}}} >> b_sh_r;
      c_ctx_nxt.m[i] = ext[i][AB-1:0];
    end
    c_ctx_nxt.neg  = b_neg_r;
    c_ctx_nxt.nz   = b_nz_r;
    c_ctx_nxt.side = b_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctx_r <= c_ctx_nxt;
    end
  end

  // Squares of the aligned magnitudes.
  logic                d_vld_r;
  ctx_t                d_ctx_r;
  logic [2:0][SQW-1:0] d_sq_r, d_sq_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_sq_nxt[i] = c_ctx_r.m[i] * c_ctx_r.m[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ctx_r <= c_ctx_r;
      d_sq_r  <= d_sq_nxt;
    end
  end

  // Square root chain, one result bit per stage; entry 0 holds the sum.
  logic            s_vld_r  [0:RW];
  logic [REMW-1:0] s_rem_r  [0:RW];
  logic [RW-1:0]   s_root_r [0:RW];
  logic [SUMW-1:0] s_n_r    [0:RW];
  ctx_t            s_ctx_r  [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r[0] <= 1'b0;
    end else if (en) begin
      s_vld_r[0] <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem_r[0]  <= '0;
      s_root_r[0] <= '0;
      s_n_r[0]    <= SUMW'(d_sq_r[0]) + SUMW'(d_sq_r[1]) + SUMW'(d_sq_r[2]);
      s_ctx_r[0]  <= d_ctx_r;
    end
  end

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    localparam int BI = 2 * (RW - 1 - g);
    logic [REMW+1:0] rem2, trial;
    logic            ge;

    always_comb begin
      rem2  = {s_rem_r[g], s_n_r[g][BI+1:BI]};
      trial = (REMW+2)'({s_root_r[g], 2'b01});
      ge    = rem2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld_r[g+1] <= 1'b0;
      end else if (en) begin
        s_vld_r[g+1] <= s_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem_r[g+1]  <= ge ? REMW'(rem2 - trial) : REMW'(rem2);
        s_root_r[g+1] <= {s_root_r[g][RW-2:0], ge};
        s_n_r[g+1]    <= s_n_r[g];
        s_ctx_r[g+1]  <= s_ctx_r[g];
      end
    end
  end

  // Rounded divide chain; entry 0 holds numerator and the length.
  logic               q_vld_r [0:QW];
  logic [2:0][NW-1:0] q_n_r   [0:QW];
  logic [2:0][RW-1:0] q_rem_r [0:QW];
  logic [2:0][QW-1:0] q_q_r   [0:QW];
  logic [RW-1:0]      q_l_r   [0:QW];
  ctx_t               q_ctx_r [0:QW];
  logic [2:0][NW-1:0] num;
  logic [RW-1:0]      len;

  always_comb begin
    len = s_root_r[RW];
    for (int i = 0; i < 3; i++) begin
      num[i] = (NW'(s_ctx_r[RW].m[i]) << K) + NW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r[0] <= 1'b0;
    end else if (en) begin
      q_vld_r[0] <= s_vld_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_n_r[0] <= num;
      for (int i = 0; i < 3; i++) begin
        q_rem_r[0][i] <= RW'(num[i][NW-1:K+1]);
      end
      q_q_r[0]   <= '0;
      q_l_r[0]   <= len;
      q_ctx_r[0] <= s_ctx_r[RW];
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int J = QW - 1 - g;
    logic [2:0][RW:0]   rem2;
    logic [2:0][RW-1:0] rem_nxt;
    logic [2:0][QW-1:0] q_nxt;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i]  = {q_rem_r[g][i], q_n_r[g][i][J]};
        q_nxt[i] = q_q_r[g][i];
        if (rem2[i] >= {1'b0, q_l_r[g]}) begin
          rem_nxt[i]  = RW'(rem2[i] - {1'b0, q_l_r[g]});
          q_nxt[i][J] = 1'b1;
        end else begin
          rem_nxt[i] = RW'(rem2[i]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_vld_r[g+1] <= 1'b0;
      end else if (en) begin
        q_vld_r[g+1] <= q_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_n_r[g+1]   <= q_n_r[g];
        q_rem_r[g+1] <= rem_nxt;
        q_q_r[g+1]   <= q_nxt;
        q_l_r[g+1]   <= q_l_r[g];
        q_ctx_r[g+1] <= q_ctx_r[g];
      end
    end
  end

  // Apply signs; a zero vector gives zero components.
  logic [2:0][K+1:0] uo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!q_ctx_r[QW].nz) begin
        uo[i] = '0;
      end else if (q_ctx_r[QW].neg[i]) begin
        uo[i] = ~{1'b0, q_q_r[QW][i]} + 1'b1;
      end else begin
        uo[i] = {1'b0, q_q_r[QW][i]};
      end
    end
  end

  assign vld_o  = q_vld_r[QW];
  assign ux_o   = uo[0];
  assign uy_o   = uo[1];
  assign uz_o   = uo[2];
  assign nz_o   = q_ctx_r[QW].nz;
  assign side_o = q_ctx_r[QW].side;

endmodule
`default_nettype wire

// ----- src/triangle_normal_and_centroid.sv -----
// Top level: triangle face normal and centroid, fully pipelined.
//
// Input channel in_*: one word per triangle, nine signed Q16.16 vertex
// coordinates. Output channel out_*: one word per triangle with the unit
// face normal (signed, NORM_FRAC_BITS fraction bits) and the centroid
// rounded to nearest; out_tuser flags a zero-length edge or normal, in
// which case the normal is zero while the centroid is still valid.
// Throughput is one triangle per cycle while the output is not stalled.
// The pipeline holds three front stages for the edges and the reciprocal
// multiply by one third, the align and square stages, the two 32-stage
// square root chains and the restoring divider chains of the edge and
// normal scalers, two cross product stages and the output register.
// Reset clears all valid bits; no result is pending afterward.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline holds and in_tready drops in the same cycle, even where the
// pipe has empty slots; nothing is lost or repeated.
`default_nettype none
module triangle_normal_and_centroid #(
  parameter int COORD_WIDTH    = tnc_pkg::COORD_WIDTH,
  parameter int NORM_FRAC_BITS = tnc_pkg::NORM_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up.
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // norm_x, norm_y, norm_z, mid_x, mid_y, mid_z from the lowest bit up.
  output logic [((3*(NORM_FRAC_BITS+2)+3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // degenerate.
  output logic [0:0] out_tuser
);
  import tnc_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int NOW   = NORM_FRAC_BITS + 2;
  localparam int OUTW  = ((3*NOW + 3*CW + 7) / 8) * 8;
  localparam int TW    = CW + 3;
  localparam int EW    = CW + 1;
  localparam int UW    = EDGE_FRAC + 2;
  localparam int PRW   = 2 * UW;
  localparam int NIW   = PRW - 1;
  localparam int LO_W  = CW / 2;
  localparam int HI_W  = CW - LO_W;
  localparam int LOB   = TW / 2;
  localparam int HIB   = TW - LOB;
  localparam int PLW   = LOB + TW;
  localparam int PHW   = HIB + TW;
  localparam int PSW   = 2 * TW;
  localparam int RS    = TW + 1;
  // One third with RS fraction bits, rounded up; exact for magnitudes below 2^TW.
  localparam logic [RS:0] RECIP_FULL =
    ({1'b1, {RS{1'b0}}} / (RS+1)'(CENTROID_DIV)) + (RS+1)'(1);
  localparam logic [TW-1:0] RECIP = RECIP_FULL[TW-1:0];

  logic en;
  logic out_vld_r;

  // The pipe advances unless a finished word is waiting.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Front stage: edges and the rounded-sum magnitude for the centroid.
  logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic [2:0][TW-1:0]   tsum;
  logic [2:0][TW-1:0]   tmag;

  assign ax = in_tdata[0*CW +: CW];
  assign ay = in_tdata[1*CW +: CW];
  assign az = in_tdata[2*CW +: CW];
  assign bx = in_tdata[3*CW +: CW];
  assign by = in_tdata[4*CW +: CW];
  assign bz = in_tdata[5*CW +: CW];
  assign cx = in_tdata[6*CW +: CW];
  assign cy = in_tdata[7*CW +: CW];
  assign cz = in_tdata[8*CW +: CW];

  always_comb begin
    tsum[0] = TW'(ax) + TW'(bx) + TW'(cx) + TW'(1);
    tsum[1] = TW'(ay) + TW'(by) + TW'(cy) + TW'(1);
    tsum[2] = TW'(az) + TW'(bz) + TW'(cz) + TW'(1);
    // Floor division of a negative sum works on (2 - sum) and negates.
    for (int i = 0; i < 3; i++) begin
      tmag[i] = tsum[i][TW-1] ? (TW'(2) - tsum[i]) : tsum[i];
    end
  end

  logic               f_vld_r;
  logic [2:0][TW-1:0] f_u_r;
  logic [2:0]         f_neg_r;
  logic [2:0][EW-1:0] f_e1_r, f_e2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_u_r     <= tmag;
      f_neg_r   <= {tsum[2][TW-1], tsum[1][TW-1], tsum[0][TW-1]};
      f_e1_r[0] <= EW'(bx) - EW'(ax);
      f_e1_r[1] <= EW'(by) - EW'(ay);
      f_e1_r[2] <= EW'(bz) - EW'(az);
      f_e2_r[0] <= EW'(cx) - EW'(bx);
      f_e2_r[1] <= EW'(cy) - EW'(by);
      f_e2_r[2] <= EW'(cz) - EW'(bz);
    end
  end

  // Multiply by the reciprocal of three, split into two partial products.
  logic                g_vld_r;
  logic [2:0][PLW-1:0] g_pl_r;
  logic [2:0][PHW-1:0] g_ph_r;
  logic [2:0]          g_neg_r;
  logic [2:0][EW-1:0]  g_e1_r, g_e2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        g_pl_r[i] <= PLW'(f_u_r[i][LOB-1:0]) * PLW'(RECIP);
        g_ph_r[i] <= PHW'(f_u_r[i][TW-1:LOB]) * PHW'(RECIP);
      end
      g_neg_r <= f_neg_r;
      g_e1_r  <= f_e1_r;
      g_e2_r  <= f_e2_r;
    end
  end

  // Combine the partial products; the quotient and sign give the centroid.
  logic [2:0][PSW-1:0] psum;
  logic [2:0][CW-1:0]  quo;
  logic [3*CW-1:0]     mid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = (PSW'(g_ph_r[i]) << LOB) + PSW'(g_pl_r[i]);
      quo[i]  = psum[i][RS +: CW];
      mid[i*CW +: CW] = g_neg_r[i] ? (~quo[i] + 1'b1) : quo[i];
    end
  end

  logic               h_vld_r;
  logic [3*CW-1:0]    h_mid_r;
  logic [2:0][EW-1:0] h_e1_r, h_e2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_mid_r <= mid;
      h_e1_r  <= g_e1_r;
      h_e2_r  <= g_e2_r;
    end
  end

  // Edge scalers; the centroid rides along split over the two units.
  logic                 e1_vld, e2_vld, e1_nz, e2_nz;
  logic signed [UW-1:0] u1x, u1y, u1z, u2x, u2y, u2z;
  logic [3*LO_W-1:0]    mid_lo;
  logic [3*HI_W-1:0]    mid_hi;
  logic [3*LO_W-1:0]    e1_side;
  logic [3*HI_W-1:0]    e2_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mid_lo[i*LO_W +: LO_W] = h_mid_r[i*CW +: LO_W];
      mid_hi[i*HI_W +: HI_W] = h_mid_r[i*CW+LO_W +: HI_W];
    end
  end

  tnc_unit #(
    .IW (EW),
    .K  (EDGE_FRAC),
    .SBW(3*LO_W)
  ) u_edge1 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (h_vld_r),
    .vx_i  (h_e1_r[0]),
    .vy_i  (h_e1_r[1]),
    .vz_i  (h_e1_r[2]),
    .side_i(mid_lo),
    .vld_o (e1_vld),
    .ux_o  (u1x),
    .uy_o  (u1y),
    .uz_o  (u1z),
    .nz_o  (e1_nz),
    .side_o(e1_side)
  );

  tnc_unit #(
    .IW (EW),
    .K  (EDGE_FRAC),
    .SBW(3*HI_W)
  ) u_edge2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (h_vld_r),
    .vx_i  (h_e2_r[0]),
    .vy_i  (h_e2_r[1]),
    .vz_i  (h_e2_r[2]),
    .side_i(mid_hi),
    .vld_o (e2_vld),
    .ux_o  (u2x),
    .uy_o  (u2y),
    .uz_o  (u2z),
    .nz_o  (e2_nz),
    .side_o(e2_side)
  );

  // Cross product, first the six products.
  logic                  x1_vld_r, x1_ok_r;
  logic [3*CW-1:0]       x1_mid_r, x1_mid_nxt;
  logic signed [PRW-1:0] p_r [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x1_mid_nxt[i*CW +: CW] = {e2_side[i*HI_W +: HI_W], e1_side[i*LO_W +: LO_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
    end else if (en) begin
      x1_vld_r <= e1_vld && e2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_ok_r  <= e1_nz && e2_nz;
      x1_mid_r <= x1_mid_nxt;
      p_r[0]   <= u1y * u2z;
      p_r[1]   <= u2y * u1z;
      p_r[2]   <= u2x * u1z;
      p_r[3]   <= u1x * u2z;
      p_r[4]   <= u1x * u2y;
      p_r[5]   <= u2x * u1y;
    end
  end

  // Cross product differences; a degenerate edge forces a zero normal.
  logic                  x2_vld_r;
  logic [3*CW-1:0]       x2_mid_r;
  logic signed [NIW-1:0] n_r [3];
  logic [PRW-1:0]        dif [3];

  always_comb begin
    dif[0] = p_r[0] - p_r[1];
    dif[1] = p_r[2] - p_r[3];
    dif[2] = p_r[4] - p_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_vld_r <= 1'b0;
    end else if (en) begin
      x2_vld_r <= x1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_mid_r <= x1_mid_r;
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= x1_ok_r ? dif[i][NIW-1:0] : '0;
      end
    end
  end

  // Normal scaler.
  logic                  nu_vld, nu_nz;
  logic signed [NOW-1:0] nux, nuy, nuz;
  logic [3*CW-1:0]       nu_mid;

  tnc_unit #(
    .IW (NIW),
    .K  (NORM_FRAC_BITS),
    .SBW(3*CW)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (x2_vld_r),
    .vx_i  (n_r[0]),
    .vy_i  (n_r[1]),
    .vz_i  (n_r[2]),
    .side_i(x2_mid_r),
    .vld_o (nu_vld),
    .ux_o  (nux),
    .uy_o  (nuy),
    .uz_o  (nuz),
    .nz_o  (nu_nz),
    .side_o(nu_mid)
  );

  // Output register.
  logic [OUTW-1:0] out_tdata_r;
  logic            out_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= nu_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= OUTW'({nu_mid, nuz, nuy, nux});
      out_deg_r   <= !nu_nz;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_deg_r;

endmodule
`default_nettype wire
